// ===== rtl/priority_runqueue_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Run queue scheduler assertion macros
// Shorthand for clocked concurrent checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUNQUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_RUNQUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// Run queue scheduler package
// Word types, register codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package prs_pkg;

	localparam int CPUS_DEF        = 4;
	localparam int PRIO_LEVELS_DEF = 140;
	localparam int POOL_SLOTS_DEF  = 512;

	// priority encoder group width
	localparam int ENC_GRP = 16;

	localparam logic [7:0] RT_QUANTUM_RST      = 8'd30;
	localparam logic [7:0] NRT_QUANTUM_RST     = 8'd10;
	localparam logic [2:0] CPUS_IN_USE_RST     = 3'd4;
	localparam logic [5:0] REQUEUE_PENALTY_RST = 6'd5;

	localparam logic FUNC_DEPARTURE = 1'b1;

	typedef enum logic [1:0] {
		CFG_RT_QUANTUM      = 2'd0,
		CFG_NRT_QUANTUM     = 2'd1,
		CFG_CPUS_IN_USE     = 2'd2,
		CFG_REQUEUE_PENALTY = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  task_id;
		logic [7:0]  burst_time;
		logic [7:0]  served_time;
		logic [7:0]  priority_req;
		logic        is_nrt;
		logic [1:0]  event_cpu;
		logic [31:0] now;
	} in_word_t;

	typedef struct packed {
		logic        dispatched;
		logic [1:0]  dispatch_cpu;
		logic [7:0]  out_task_id;
		logic [7:0]  out_burst;
		logic [7:0]  out_served;
		logic [7:0]  out_priority;
		logic        out_is_nrt;
		logic [31:0] slice_end;
		logic        task_done;
		logic        banks_swapped;
		logic        pool_overflow;
	} out_word_t;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] burst;
		logic [7:0] served;
		logic [7:0] prio;
		logic       nrt;
	} task_rec_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROUTE,
		ST_PUSH_RD,
		ST_PUSH_WR,
		ST_PUSH_LINK,
		ST_SWAP,
		ST_DSP,
		ST_ENC_A,
		ST_ENC_B,
		ST_HEAD_RD,
		ST_SLOT_RD,
		ST_POP,
		ST_OUT
	} prs_state_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic route;
		logic push_rd;
		logic push_wr;
		logic push_link;
		logic swap;
		logic dsp;
		logic enc_a;
		logic enc_b;
		logic head_rd;
		logic slot_rd;
		logic pop;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_dep;
		logic cpu_ok;
		logic do_push;
		logic pool_empty;
		logic lvl_was_set;
		logic dsp_ok;
	} dp_stat_t;

endpackage

// ===== rtl/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Run queue scheduler controller
// Sequences clear pass, push, bank swap, dispatch search and pop.
// ----------------------------------------------------------------------------
module prs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_stall,
	input  prs_pkg::dp_stat_t  st,
	output prs_pkg::ctrl_cmd_t cmd,
	output logic               in_stall,
	output logic               out_valid
);

	prs_pkg::prs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prs_pkg::ST_CLEAR: begin
				if (st.clr_last) state_d = prs_pkg::ST_IDLE;
			end
			prs_pkg::ST_IDLE: begin
				if (in_valid) state_d = prs_pkg::ST_ROUTE;
			end
			prs_pkg::ST_ROUTE: begin
				if (st.is_dep && !st.cpu_ok) state_d = prs_pkg::ST_OUT;
				else if (st.do_push) state_d = prs_pkg::ST_PUSH_RD;
				else state_d = prs_pkg::ST_SWAP;
			end
			prs_pkg::ST_PUSH_RD: begin
				if (!st.pool_empty) state_d = prs_pkg::ST_PUSH_WR;
				else if (st.is_dep) state_d = prs_pkg::ST_SWAP;
				else state_d = prs_pkg::ST_DSP;
			end
			prs_pkg::ST_PUSH_WR: begin
				if (st.lvl_was_set) state_d = prs_pkg::ST_PUSH_LINK;
				else if (st.is_dep) state_d = prs_pkg::ST_SWAP;
				else state_d = prs_pkg::ST_DSP;
			end
			prs_pkg::ST_PUSH_LINK: begin
				state_d = st.is_dep ? prs_pkg::ST_SWAP : prs_pkg::ST_DSP;
			end
			prs_pkg::ST_SWAP:    state_d = prs_pkg::ST_DSP;
			prs_pkg::ST_DSP: begin
				state_d = st.dsp_ok ? prs_pkg::ST_ENC_A : prs_pkg::ST_OUT;
			end
			prs_pkg::ST_ENC_A:   state_d = prs_pkg::ST_ENC_B;
			prs_pkg::ST_ENC_B:   state_d = prs_pkg::ST_HEAD_RD;
			prs_pkg::ST_HEAD_RD: state_d = prs_pkg::ST_SLOT_RD;
			prs_pkg::ST_SLOT_RD: state_d = prs_pkg::ST_POP;
			prs_pkg::ST_POP:     state_d = prs_pkg::ST_OUT;
			prs_pkg::ST_OUT: begin
				if (!out_stall) state_d = prs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.clr       = (state_q == prs_pkg::ST_CLEAR);
		cmd.take      = (state_q == prs_pkg::ST_IDLE) && in_valid;
		cmd.route     = (state_q == prs_pkg::ST_ROUTE);
		cmd.push_rd   = (state_q == prs_pkg::ST_PUSH_RD);
		cmd.push_wr   = (state_q == prs_pkg::ST_PUSH_WR);
		cmd.push_link = (state_q == prs_pkg::ST_PUSH_LINK);
		cmd.swap      = (state_q == prs_pkg::ST_SWAP);
		cmd.dsp       = (state_q == prs_pkg::ST_DSP);
		cmd.enc_a     = (state_q == prs_pkg::ST_ENC_A);
		cmd.enc_b     = (state_q == prs_pkg::ST_ENC_B);
		cmd.head_rd   = (state_q == prs_pkg::ST_HEAD_RD);
		cmd.slot_rd   = (state_q == prs_pkg::ST_SLOT_RD);
		cmd.pop       = (state_q == prs_pkg::ST_POP);
		in_stall      = (state_q != prs_pkg::ST_IDLE);
		out_valid     = (state_q == prs_pkg::ST_OUT);
	end

endmodule

// ===== rtl/prs_dp.sv =====
// ----------------------------------------------------------------------------
// Run queue scheduler datapath
// Task pool, level queues, occupancy rows, per-CPU state and result word.
// ----------------------------------------------------------------------------
module prs_dp #(
	parameter int CPUS        = prs_pkg::CPUS_DEF,
	parameter int PRIO_LEVELS = prs_pkg::PRIO_LEVELS_DEF,
	parameter int POOL_SLOTS  = prs_pkg::POOL_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  prs_pkg::ctrl_cmd_t cmd,
	output prs_pkg::dp_stat_t  st,
	input  prs_pkg::in_word_t  in_data,
	output prs_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int BANKS  = 2 * CPUS;
	localparam int CW     = (CPUS > 1) ? $clog2(CPUS) : 1;
	localparam int BKW    = CW + 1;
	localparam int LVW    = $clog2(PRIO_LEVELS);
	localparam int SIW    = $clog2(POOL_SLOTS);
	localparam int LKW    = $clog2(POOL_SLOTS + 1);
	localparam int LSLOTS = BANKS * PRIO_LEVELS;
	localparam int LIW    = $clog2(LSLOTS);
	localparam int NG     = (PRIO_LEVELS + prs_pkg::ENC_GRP - 1) / prs_pkg::ENC_GRP;
	localparam int PADW   = NG * prs_pkg::ENC_GRP;
	localparam int GIW    = $clog2(prs_pkg::ENC_GRP);
	localparam int CLR_N  = (POOL_SLOTS > BANKS) ? POOL_SLOTS : BANKS;
	localparam int CCW    = $clog2(CLR_N);
	localparam logic [LKW-1:0] LINK_END = LKW'(POOL_SLOTS);
	localparam logic [7:0]     PRIO_MAX = 8'(PRIO_LEVELS - 1);

	// memories
	prs_pkg::task_rec_t     task_mem [POOL_SLOTS];
	logic [LKW-1:0]         link_mem [POOL_SLOTS];
	logic [SIW-1:0]         head_mem [LSLOTS];
	logic [SIW-1:0]         tail_mem [LSLOTS];
	logic [PRIO_LEVELS-1:0] row_mem  [BANKS];

	// config
	logic [7:0] rt_quantum_q, nrt_quantum_q;
	logic [2:0] cpus_in_use_q;
	logic [5:0] requeue_penalty_q;

	// control state
	logic [CCW-1:0] clr_cnt_q;
	logic [LKW-1:0] free_head_q;
	logic [LKW-1:0] total0_q [CPUS];
	logic [LKW-1:0] total1_q [CPUS];
	logic           active_q [CPUS];
	logic           idle_q   [CPUS];
	logic [CW-1:0]  next_cpu_q, cpu_q;
	logic           side_q, is_dep_q, cpu_ok_q, do_push_q;

	// payload
	prs_pkg::in_word_t  item_q;
	prs_pkg::out_word_t res_q;
	prs_pkg::task_rec_t rec_rd_q;
	logic [7:0]         prio_q;
	logic [SIW-1:0]     slot_q, head_rd_q, tail_rd_q;
	logic [LKW-1:0]     link_rd_q;
	logic [PRIO_LEVELS-1:0] row_rd_q;
	logic [NG-1:0]          grp_any_s1;
	logic [NG-1:0][GIW-1:0] grp_idx_s1;
	logic [LVW-1:0]         lv_q;

	// combinational
	logic [BKW-1:0]     bank_cur, row_raddr, row_waddr;
	logic [LIW-1:0]     lidx_push, lidx_pop, head_waddr;
	logic               act_cur;
	logic [LKW-1:0]     tot_act, tot_exp;
	logic               link_we, link_re, row_we, row_re, head_we;
	logic [SIW-1:0]     link_waddr, link_raddr, head_wdata;
	logic [LKW-1:0]     link_wdata;
	logic [PRIO_LEVELS-1:0] row_wdata;
	logic [NG-1:0]          grp_any_d;
	logic [NG-1:0][GIW-1:0] grp_idx_d;
	logic [LVW-1:0]     lv_d;
	logic               take_dep, take_ok, take_more;
	logic [7:0]         prio_clamp, prio_take;
	logic [8:0]         pen_sum;
	logic [CW-1:0]      cpu_next_rr;
	int                 used_n;
	logic [7:0]         quantum, rem, slice;
	prs_pkg::task_rec_t rec_new;
	prs_pkg::out_word_t res_take;

	assign cfg_ready = 1'b1;
	assign out_data  = res_q;

	assign bank_cur  = {cpu_q, side_q};
	assign act_cur   = active_q[cpu_q];
	assign tot_act   = act_cur ? total1_q[cpu_q] : total0_q[cpu_q];
	assign tot_exp   = act_cur ? total0_q[cpu_q] : total1_q[cpu_q];
	assign lidx_push = LIW'(int'(bank_cur) * PRIO_LEVELS + int'(prio_q));
	assign lidx_pop  = LIW'(int'(bank_cur) * PRIO_LEVELS + int'(lv_q));
	assign rec_new   = '{id: item_q.task_id, burst: item_q.burst_time,
		served: item_q.served_time, prio: prio_q, nrt: item_q.is_nrt};

	assign st.clr_last    = (clr_cnt_q == CCW'(CLR_N - 1));
	assign st.is_dep      = is_dep_q;
	assign st.cpu_ok      = cpu_ok_q;
	assign st.do_push     = do_push_q;
	assign st.pool_empty  = (free_head_q == LINK_END);
	assign st.lvl_was_set = row_rd_q[prio_q[LVW-1:0]];
	assign st.dsp_ok      = cpu_ok_q && idle_q[cpu_q] && (tot_act != '0);

	// event decode at accept
	always_comb begin
		take_dep   = (in_data.func == prs_pkg::FUNC_DEPARTURE);
		take_ok    = !take_dep || (int'(in_data.event_cpu) < CPUS);
		take_more  = in_data.served_time < in_data.burst_time;
		prio_clamp = (in_data.priority_req > PRIO_MAX) ? PRIO_MAX : in_data.priority_req;
		pen_sum    = {1'b0, prio_clamp} + 9'(requeue_penalty_q);
		if (take_dep && in_data.is_nrt)
			prio_take = (pen_sum > {1'b0, PRIO_MAX}) ? PRIO_MAX : pen_sum[7:0];
		else
			prio_take = prio_clamp;
		if (cpus_in_use_q == 3'd0) used_n = 1;
		else if (int'(cpus_in_use_q) > CPUS) used_n = CPUS;
		else used_n = int'(cpus_in_use_q);
		cpu_next_rr = (int'(next_cpu_q) + 1 >= used_n) ? '0 : CW'(int'(next_cpu_q) + 1);
		res_take           = '0;
		res_take.task_done = take_dep && take_ok && !take_more;
	end

	// slice for the popped task
	always_comb begin
		quantum = rec_rd_q.nrt ? nrt_quantum_q : rt_quantum_q;
		rem     = (rec_rd_q.burst > rec_rd_q.served) ? rec_rd_q.burst - rec_rd_q.served : 8'd0;
		slice   = (rem < quantum) ? rem : quantum;
	end

	// group-wise first set bit of the occupancy row
	always_comb begin
		logic [PADW-1:0]              padded;
		logic [prs_pkg::ENC_GRP-1:0]  sub;
		padded = PADW'(row_rd_q);
		for (int g = 0; g < NG; g++) begin
			sub          = padded[g*prs_pkg::ENC_GRP +: prs_pkg::ENC_GRP];
			grp_any_d[g] = |sub;
			grp_idx_d[g] = '0;
			for (int j = prs_pkg::ENC_GRP - 1; j >= 0; j--) begin
				if (sub[j]) grp_idx_d[g] = GIW'(j);
			end
		end
	end

	always_comb begin
		lv_d = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) lv_d = LVW'(g * prs_pkg::ENC_GRP + int'(grp_idx_s1[g]));
		end
	end

	// memory port muxing
	always_comb begin
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		if (cmd.clr && int'(clr_cnt_q) < POOL_SLOTS) begin
			link_we    = 1'b1;
			link_waddr = SIW'(clr_cnt_q);
			link_wdata = LKW'(int'(clr_cnt_q) + 1);
		end else if (cmd.push_wr) begin
			link_we    = 1'b1;
			link_waddr = free_head_q[SIW-1:0];
			link_wdata = LINK_END;
		end else if (cmd.push_link) begin
			link_we    = 1'b1;
			link_waddr = tail_rd_q;
			link_wdata = LKW'(slot_q);
		end else if (cmd.pop) begin
			link_we    = 1'b1;
			link_waddr = slot_q;
			link_wdata = free_head_q;
		end
		link_re    = (cmd.push_rd && !st.pool_empty) || cmd.slot_rd;
		link_raddr = cmd.push_rd ? free_head_q[SIW-1:0] : head_rd_q;

		row_we    = 1'b0;
		row_waddr = bank_cur;
		row_wdata = row_rd_q;
		if (cmd.clr && int'(clr_cnt_q) < BANKS) begin
			row_we    = 1'b1;
			row_waddr = BKW'(clr_cnt_q);
			row_wdata = '0;
		end else if (cmd.push_wr) begin
			row_we                     = 1'b1;
			row_wdata[prio_q[LVW-1:0]] = 1'b1;
		end else if (cmd.pop && link_rd_q == LINK_END) begin
			row_we          = 1'b1;
			row_wdata[lv_q] = 1'b0;
		end
		row_re    = cmd.push_rd || cmd.dsp;
		row_raddr = cmd.dsp ? {cpu_q, act_cur} : bank_cur;

		head_we    = 1'b0;
		head_waddr = lidx_push;
		head_wdata = free_head_q[SIW-1:0];
		if (cmd.push_wr && !st.lvl_was_set) begin
			head_we = 1'b1;
		end else if (cmd.pop) begin
			head_we    = 1'b1;
			head_waddr = lidx_pop;
			head_wdata = link_rd_q[SIW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_waddr] <= link_wdata;
		if (link_re) link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_waddr] <= row_wdata;
		if (row_re) row_rd_q <= row_mem[row_raddr];
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		if (cmd.head_rd) head_rd_q <= head_mem[lidx_pop];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_wr) tail_mem[lidx_push] <= free_head_q[SIW-1:0];
		if (cmd.push_rd) tail_rd_q <= tail_mem[lidx_push];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_wr) task_mem[free_head_q[SIW-1:0]] <= rec_new;
		if (cmd.slot_rd) rec_rd_q <= task_mem[head_rd_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_quantum_q      <= prs_pkg::RT_QUANTUM_RST;
			nrt_quantum_q     <= prs_pkg::NRT_QUANTUM_RST;
			cpus_in_use_q     <= prs_pkg::CPUS_IN_USE_RST;
			requeue_penalty_q <= prs_pkg::REQUEUE_PENALTY_RST;
			clr_cnt_q         <= '0;
			free_head_q       <= '0;
			next_cpu_q        <= '0;
			cpu_q             <= '0;
			side_q            <= 1'b0;
			is_dep_q          <= 1'b0;
			cpu_ok_q          <= 1'b0;
			do_push_q         <= 1'b0;
			for (int c = 0; c < CPUS; c++) begin
				total0_q[c] <= '0;
				total1_q[c] <= '0;
				active_q[c] <= 1'b0;
				idle_q[c]   <= 1'b1;
			end
		end else begin
			if (cfg_valid) begin
				unique case (prs_pkg::cfg_reg_t'(cfg_index))
					prs_pkg::CFG_RT_QUANTUM:      rt_quantum_q      <= cfg_data;
					prs_pkg::CFG_NRT_QUANTUM:     nrt_quantum_q     <= cfg_data;
					prs_pkg::CFG_CPUS_IN_USE:     cpus_in_use_q     <= cfg_data[2:0];
					prs_pkg::CFG_REQUEUE_PENALTY: requeue_penalty_q <= cfg_data[5:0];
				endcase
			end
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.take) begin
				is_dep_q  <= take_dep;
				cpu_ok_q  <= take_ok;
				do_push_q <= !take_dep || take_more;
				if (take_dep) begin
					cpu_q <= CW'(in_data.event_cpu);
				end else begin
					cpu_q      <= next_cpu_q;
					next_cpu_q <= cpu_next_rr;
				end
			end
			if (cmd.route) begin
				side_q <= is_dep_q ? !act_cur : act_cur;
				if (is_dep_q && cpu_ok_q) idle_q[cpu_q] <= 1'b1;
			end
			if (cmd.push_wr) begin
				free_head_q <= link_rd_q;
				if (side_q) total1_q[cpu_q] <= total1_q[cpu_q] + 1'b1;
				else total0_q[cpu_q] <= total0_q[cpu_q] + 1'b1;
			end
			if (cmd.swap && tot_act == '0 && tot_exp != '0) active_q[cpu_q] <= !act_cur;
			if (cmd.dsp) side_q <= act_cur;
			if (cmd.pop) begin
				free_head_q   <= LKW'(slot_q);
				idle_q[cpu_q] <= 1'b0;
				if (side_q) total1_q[cpu_q] <= total1_q[cpu_q] - 1'b1;
				else total0_q[cpu_q] <= total0_q[cpu_q] - 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_data;
			prio_q <= prio_take;
			res_q  <= res_take;
		end
		if (cmd.push_rd && st.pool_empty) res_q.pool_overflow <= 1'b1;
		if (cmd.push_wr) slot_q <= free_head_q[SIW-1:0];
		if (cmd.swap && tot_act == '0 && tot_exp != '0) res_q.banks_swapped <= 1'b1;
		if (cmd.enc_a) begin
			grp_any_s1 <= grp_any_d;
			grp_idx_s1 <= grp_idx_d;
		end
		if (cmd.enc_b) lv_q <= lv_d;
		if (cmd.slot_rd) slot_q <= head_rd_q;
		if (cmd.pop) begin
			res_q.dispatched   <= 1'b1;
			res_q.dispatch_cpu <= 2'(cpu_q);
			res_q.out_task_id  <= rec_rd_q.id;
			res_q.out_burst    <= rec_rd_q.burst;
			res_q.out_served   <= rec_rd_q.served + slice;
			res_q.out_priority <= rec_rd_q.prio;
			res_q.out_is_nrt   <= rec_rd_q.nrt;
			res_q.slice_end    <= item_q.now + 32'(slice);
		end
	end

endmodule

// ===== rtl/priority_runqueue_scheduler.sv =====
// ----------------------------------------------------------------------------
// Priority run queue scheduler
// Per-CPU active/expired banks of FIFO priority levels over a shared pool.
// ----------------------------------------------------------------------------
// One event word in, one result word out. An arrival is queued on the next
// CPU in round-robin order; a departure frees its CPU, requeues an unfinished
// task into the expired bank (non-real-time tasks drop by the penalty),
// swaps banks when the active one runs dry, and the CPU then dispatches the
// head of its best non-empty level. Events are handled one at a time; the
// result word waits out any stall before the next event is taken. Work is
// sequenced as a chain of registered reads into single-port queue
// memories (free list link, level tail, occupancy row, level head, task
// record) and the two-stage priority encoder over a bank's occupancy row.
// After reset a clearing pass builds the free list and empties the
// occupancy rows; input is stalled meanwhile, configuration writes are
// taken at any time (cfg_ready is always high).
module priority_runqueue_scheduler #(
	parameter int CPUS        = prs_pkg::CPUS_DEF,
	parameter int PRIO_LEVELS = prs_pkg::PRIO_LEVELS_DEF,
	parameter int POOL_SLOTS  = prs_pkg::POOL_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// event words
	input  logic               in_valid,
	output logic               in_stall,
	input  prs_pkg::in_word_t  in_data,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output prs_pkg::out_word_t out_data,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	prs_pkg::ctrl_cmd_t cmd;
	prs_pkg::dp_stat_t  st;

	// sequencer: one state per step of an event
	prs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// queues, pool, per-CPU bookkeeping and the result register
	prs_dp #(
		.CPUS        (CPUS),
		.PRIO_LEVELS (PRIO_LEVELS),
		.POOL_SLOTS  (POOL_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ===== rtl/prs_checker.sv =====
// ----------------------------------------------------------------------------
// Run queue scheduler port checker
// Port-level checks on the event and result channels.
// ----------------------------------------------------------------------------
`include "priority_runqueue_scheduler_assert.svh"

module prs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input prs_pkg::out_word_t out_data
);

	`PRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")
	`PRS_ASSERT_NOW(a_one_event, out_valid, in_stall, "event taken while result pending")
	`PRS_ASSERT_NEXT(a_no_instant, in_valid && !in_stall, !out_valid, "result too early")
	`PRS_ASSERT_NOW(a_idle_zero, out_valid && !out_data.dispatched, out_data.slice_end == 32'd0 && out_data.out_task_id == 8'd0 && out_data.dispatch_cpu == 2'd0, "fields set without dispatch")

endmodule

bind priority_runqueue_scheduler prs_checker u_prs_checker (.*);
